>>> rtl/mvat_pkg.sv
package mvat_pkg;

   // sizing
   localparam int MAX_VERTICES  = 4096;
   localparam int LIST_SLOTS    = 12;
   localparam int VIDX_W        = $clog2(MAX_VERTICES);
   localparam int VCOUNT_W      = VIDX_W + 1;
   localparam int CNT_W         = $clog2(LIST_SLOTS + 1);
   localparam int STORE_DEPTH   = MAX_VERTICES * LIST_SLOTS;
   localparam int STORE_AW      = $clog2(STORE_DEPTH);
   localparam int WORD_W        = 12;

   // request codes
   typedef enum logic [1:0] {
      REQ_ADD   = 2'd0,
      REQ_QUERY = 2'd1,
      REQ_CLEAR = 2'd2
   } req_kind_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_REJECT    = 2'd1,
      ST_DROPPED   = 2'd2,
      ST_BAD_QUERY = 2'd3
   } status_type;

   // count memory access, one address for read and write
   typedef struct packed {
      logic              wr_en;
      logic [VIDX_W-1:0] addr;
      logic [CNT_W-1:0]  wdata;
   } cnt_port_type;

   // neighbour list memory access
   typedef struct packed {
      logic                wr_en;
      logic [STORE_AW-1:0] addr;
      logic [VIDX_W-1:0]   wdata;
   } list_port_type;

   // first list entry of a vertex
   function automatic logic [STORE_AW-1:0] list_base(input logic [VIDX_W-1:0] v);
      list_base = STORE_AW'(v) * STORE_AW'(LIST_SLOTS);
   endfunction

endpackage

>>> rtl/mvat_count_mem.sv
module mvat_count_mem (
   input  logic                            clock,
   input  mvat_pkg::cnt_port_type          port,
   output logic [mvat_pkg::CNT_W-1:0]      rd_data_ff
);

   logic [mvat_pkg::CNT_W-1:0] count_ram [mvat_pkg::MAX_VERTICES];

   // write on enable, register the read word every cycle
   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         count_ram[port.addr] <= port.wdata;
      end
      rd_data_ff <= count_ram[port.addr];
   end

endmodule

>>> rtl/mvat_list_mem.sv
module mvat_list_mem (
   input  logic                            clock,
   input  mvat_pkg::list_port_type         port,
   output logic [mvat_pkg::VIDX_W-1:0]     rd_data_ff
);

   logic [mvat_pkg::VIDX_W-1:0] list_ram [mvat_pkg::STORE_DEPTH];

   // write on enable, register the read word every cycle
   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         list_ram[port.addr] <= port.wdata;
      end
      rd_data_ff <= list_ram[port.addr];
   end

endmodule

>>> rtl/mvat_probe.sv
module mvat_probe (
   input  logic [mvat_pkg::STORE_AW-1:0] base,
   input  logic [mvat_pkg::CNT_W-1:0]    offset,
   input  logic [mvat_pkg::VIDX_W-1:0]   rd_data,
   input  logic [mvat_pkg::VIDX_W-1:0]   key,
   output logic [mvat_pkg::STORE_AW-1:0] addr,
   output logic                          match
);

   // entry address within the vertex's list
   assign addr  = base + mvat_pkg::STORE_AW'(offset);

   // compare the fetched entry against the neighbour being inserted
   assign match = (rd_data == key);

endmodule

>>> rtl/mvat_ctrl.sv
module mvat_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [1:0]                        req_type,
   input  logic [mvat_pkg::VIDX_W-1:0]       req_vertex_a,
   input  logic [mvat_pkg::VIDX_W-1:0]       req_vertex_b,
   input  logic [mvat_pkg::VIDX_W-1:0]       req_vertex_c,
   input  logic [mvat_pkg::VIDX_W-1:0]       req_query_vertex,
   input  logic                              csr_wr_en,
   input  logic [mvat_pkg::VCOUNT_W-1:0]     csr_wr_data,
   output logic                              busy,
   output logic                              rsp_valid,
   output logic [mvat_pkg::WORD_W-1:0]       rsp_word,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_last,
   output mvat_pkg::cnt_port_type            cnt_port,
   input  logic [mvat_pkg::CNT_W-1:0]        cnt_rdata,
   output mvat_pkg::list_port_type           list_port,
   input  logic [mvat_pkg::VIDX_W-1:0]       list_rdata
);

   localparam int PAIR_W = 3;
   localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(5);
   localparam logic [mvat_pkg::CNT_W-1:0] MAX_CNT = mvat_pkg::CNT_W'(mvat_pkg::LIST_SLOTS);
   localparam logic [mvat_pkg::CNT_W-1:0] LAST_SLOT =
      mvat_pkg::CNT_W'(mvat_pkg::LIST_SLOTS - 1);
   localparam logic [mvat_pkg::VIDX_W-1:0] LAST_VERTEX =
      mvat_pkg::VIDX_W'(mvat_pkg::MAX_VERTICES - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SWEEP,
      S_LOAD,
      S_CNTGOT,
      S_SCAN,
      S_QLOAD,
      S_QCNT,
      S_QLIST,
      S_QBAD
   } state_type;

   state_type                        state_ff, state_in;
   logic [mvat_pkg::VIDX_W-1:0]      vert_a_ff, vert_a_in;
   logic [mvat_pkg::VIDX_W-1:0]      vert_b_ff, vert_b_in;
   logic [mvat_pkg::VIDX_W-1:0]      vert_c_ff, vert_c_in;
   logic [mvat_pkg::VIDX_W-1:0]      cur_v_ff, cur_v_in;
   logic [mvat_pkg::VIDX_W-1:0]      key_ff, key_in;
   logic [mvat_pkg::STORE_AW-1:0]    base_ff, base_in;
   logic [PAIR_W-1:0]                pair_ff, pair_in;
   logic [mvat_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [mvat_pkg::CNT_W-1:0]       idx_ff, idx_in;
   logic [mvat_pkg::CNT_W-1:0]       pend_idx_ff, pend_idx_in;
   logic                             pend_ff, pend_in;
   logic                             drop_ff, drop_in;
   logic [mvat_pkg::VIDX_W-1:0]      sweep_ff, sweep_in;
   logic                             clear_rsp_ff, clear_rsp_in;
   logic [mvat_pkg::VCOUNT_W-1:0]    vcount_ff, vcount_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [mvat_pkg::WORD_W-1:0]      rsp_word_ff, rsp_word_in;
   mvat_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic [mvat_pkg::VIDX_W-1:0]      pair_v;
   logic [mvat_pkg::VIDX_W-1:0]      pair_n;
   logic [mvat_pkg::STORE_AW-1:0]    probe_addr;
   logic                             probe_match;
   logic                             bad_tri;
   logic                             hit;
   logic                             exhausted;
   logic                             drop_now;
   logic [mvat_pkg::CNT_W-1:0]       cnt_clamped;

   // shared address adder and entry comparator
   mvat_probe u_probe (
      .base    (base_ff),
      .offset  (idx_ff),
      .rd_data (list_rdata),
      .key     (key_ff),
      .addr    (probe_addr),
      .match   (probe_match)
   );

   // pick the owner vertex and the new neighbour of the current pair
   always_comb begin
      unique case (pair_ff)
         PAIR_W'(0): begin pair_v = vert_a_ff; pair_n = vert_b_ff; end
         PAIR_W'(1): begin pair_v = vert_a_ff; pair_n = vert_c_ff; end
         PAIR_W'(2): begin pair_v = vert_b_ff; pair_n = vert_a_ff; end
         PAIR_W'(3): begin pair_v = vert_b_ff; pair_n = vert_c_ff; end
         PAIR_W'(4): begin pair_v = vert_c_ff; pair_n = vert_a_ff; end
         default:    begin pair_v = vert_c_ff; pair_n = vert_b_ff; end
      endcase
   end

   assign bad_tri = (mvat_pkg::VCOUNT_W'(req_vertex_a) >= vcount_ff) ||
                    (mvat_pkg::VCOUNT_W'(req_vertex_b) >= vcount_ff) ||
                    (mvat_pkg::VCOUNT_W'(req_vertex_c) >= vcount_ff);
   assign hit         = pend_ff && probe_match;
   assign exhausted   = (idx_ff == cnt_ff);
   assign drop_now    = (cnt_ff >= MAX_CNT);
   assign cnt_clamped = (cnt_rdata > MAX_CNT) ? MAX_CNT : cnt_rdata;

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      vert_a_in     = vert_a_ff;
      vert_b_in     = vert_b_ff;
      vert_c_in     = vert_c_ff;
      cur_v_in      = cur_v_ff;
      key_in        = key_ff;
      base_in       = base_ff;
      pair_in       = pair_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      pend_idx_in   = pend_idx_ff;
      pend_in       = pend_ff;
      drop_in       = drop_ff;
      sweep_in      = sweep_ff;
      clear_rsp_in  = clear_rsp_ff;
      vcount_in     = csr_wr_en ? csr_wr_data : vcount_ff;
      rsp_valid_in  = 1'b0;
      rsp_word_in   = '0;
      rsp_status_in = mvat_pkg::ST_OK;
      rsp_last_in   = 1'b0;
      cnt_port      = '{wr_en: 1'b0, addr: cur_v_ff, wdata: cnt_ff + 1'b1};
      list_port     = '{wr_en: 1'b0, addr: probe_addr, wdata: key_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               vert_a_in = req_vertex_a;
               vert_b_in = req_vertex_b;
               vert_c_in = req_vertex_c;
               case (req_type)
                  mvat_pkg::REQ_ADD: begin
                     if (bad_tri) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = mvat_pkg::ST_REJECT;
                        rsp_last_in   = 1'b1;
                     end else begin
                        pair_in  = '0;
                        drop_in  = 1'b0;
                        state_in = S_LOAD;
                     end
                  end
                  mvat_pkg::REQ_QUERY: begin
                     cur_v_in = req_query_vertex;
                     idx_in   = '0;
                     if (mvat_pkg::VCOUNT_W'(req_query_vertex) >= vcount_ff) begin
                        state_in = S_QBAD;
                     end else begin
                        state_in = S_QLOAD;
                     end
                  end
                  mvat_pkg::REQ_CLEAR: begin
                     sweep_in     = '0;
                     clear_rsp_in = 1'b1;
                     state_in     = S_SWEEP;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // zero one count per cycle
         S_SWEEP: begin
            cnt_port = '{wr_en: 1'b1, addr: sweep_ff, wdata: '0};
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_VERTEX) begin
               state_in     = S_IDLE;
               clear_rsp_in = 1'b0;
               if (clear_rsp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
               end
            end
         end

         // fetch the owner's count
         S_LOAD: begin
            cnt_port.addr = pair_v;
            cur_v_in      = pair_v;
            key_in        = pair_n;
            base_in       = mvat_pkg::list_base(pair_v);
            state_in      = S_CNTGOT;
         end

         S_CNTGOT: begin
            cnt_in   = cnt_rdata;
            idx_in   = '0;
            pend_in  = 1'b0;
            state_in = S_SCAN;
         end

         // read one entry a cycle, compare the one read before
         S_SCAN: begin
            if (hit || exhausted) begin
               if (!hit) begin
                  if (drop_now) begin
                     drop_in = 1'b1;
                  end else begin
                     list_port.wr_en = 1'b1;
                     cnt_port.wr_en  = 1'b1;
                  end
               end
               pend_in = 1'b0;
               if (pair_ff == LAST_PAIR) begin
                  rsp_valid_in  = 1'b1;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = (drop_ff || (!hit && drop_now)) ?
                                  mvat_pkg::ST_DROPPED : mvat_pkg::ST_OK;
                  state_in      = S_IDLE;
               end else begin
                  pair_in  = pair_ff + 1'b1;
                  state_in = S_LOAD;
               end
            end else begin
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end
         end

         S_QLOAD: begin
            base_in  = mvat_pkg::list_base(cur_v_ff);
            state_in = S_QCNT;
         end

         // emit the count word
         S_QCNT: begin
            cnt_in       = cnt_clamped;
            idx_in       = '0;
            pend_in      = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_word_in  = mvat_pkg::WORD_W'(cnt_clamped);
            state_in     = S_QLIST;
         end

         // stream the list, padding past the count with zero
         S_QLIST: begin
            if (idx_ff != MAX_CNT) begin
               idx_in      = idx_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = (pend_idx_ff < cnt_ff) ? mvat_pkg::WORD_W'(list_rdata) : '0;
               rsp_last_in  = (pend_idx_ff == LAST_SLOT);
               if (pend_idx_ff == LAST_SLOT) begin
                  state_in = S_IDLE;
               end
            end
         end

         S_QBAD: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = mvat_pkg::ST_BAD_QUERY;
            rsp_last_in   = (idx_ff == MAX_CNT);
            idx_in        = idx_ff + 1'b1;
            if (idx_ff == MAX_CNT) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         sweep_ff      <= '0;
         clear_rsp_ff  <= 1'b0;
         pend_ff       <= 1'b0;
         drop_ff       <= 1'b0;
         vcount_ff     <= mvat_pkg::VCOUNT_W'(mvat_pkg::MAX_VERTICES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         clear_rsp_ff  <= clear_rsp_in;
         pend_ff       <= pend_in;
         drop_ff       <= drop_in;
         vcount_ff     <= vcount_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      vert_a_ff     <= vert_a_in;
      vert_b_ff     <= vert_b_in;
      vert_c_ff     <= vert_c_in;
      cur_v_ff      <= cur_v_in;
      key_ff        <= key_in;
      base_ff       <= base_in;
      pair_ff       <= pair_in;
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      pend_idx_ff   <= pend_idx_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   // a list never grows past its capacity
   a_list_write_room: assert property (@(posedge clock) disable iff (reset)
      list_port.wr_en |-> (cnt_ff < MAX_CNT))
      else $error("list write with full list");

   // count write during an insert always pairs with a list write
   a_count_with_list: assert property (@(posedge clock) disable iff (reset)
      (cnt_port.wr_en && state_ff == S_SCAN) |-> list_port.wr_en)
      else $error("count bumped without list entry");

   // an invalid query never reports a neighbour
   a_bad_query_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == mvat_pkg::ST_BAD_QUERY) |-> (rsp_word_ff == '0))
      else $error("invalid query returned data");

   // the final word of an item returns the sequencer to idle
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> !busy)
      else $error("last word while still busy");

   // a stray last flag never leaks without its strobe
   a_last_strobed: assert property (@(posedge clock) disable iff (reset)
      rsp_last_ff |-> rsp_valid_ff)
      else $error("last without strobe");

endmodule

>>> rtl/mesh_vertex_adjacency_table_top.sv
// Per-vertex neighbour lists of a triangle mesh, up to twelve distinct
// entries per vertex. Pulse start while busy is low to hand in one request.
// Results come out as single-cycle rsp_valid strobes that cannot be held off;
// rsp_last marks the final word of each answered request (an unknown request
// code gives no result). After reset, and for every clear request, the block
// zeroes the 4096 list counts one per cycle and stays busy for the sweep (the
// clear result follows the sweep). An add works through six vertex pairs per
// triangle; each pair loads the owner's count, then compares its stored entries
// one per cycle, as the single-port list memory is read once per cycle.
// A rejected triangle answers the cycle after acceptance. A query gives 13
// words. vertex_count is written through csr_wr_en and csr_wr_data; the user
// must do so only while the block is idle, which the block does not enforce.
module mesh_vertex_adjacency_table_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_type,
   input  logic [mvat_pkg::VIDX_W-1:0]     req_vertex_a,
   input  logic [mvat_pkg::VIDX_W-1:0]     req_vertex_b,
   input  logic [mvat_pkg::VIDX_W-1:0]     req_vertex_c,
   input  logic [mvat_pkg::VIDX_W-1:0]     req_query_vertex,
   input  logic                            csr_wr_en,
   input  logic [mvat_pkg::VCOUNT_W-1:0]   csr_wr_data,
   output logic                            rsp_valid,
   output logic [mvat_pkg::WORD_W-1:0]     rsp_word,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_last
);

   mvat_pkg::cnt_port_type       cnt_port;
   mvat_pkg::list_port_type      list_port;
   logic [mvat_pkg::CNT_W-1:0]   cnt_rdata;
   logic [mvat_pkg::VIDX_W-1:0]  list_rdata;

   // sequencer
   mvat_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_type         (req_type),
      .req_vertex_a     (req_vertex_a),
      .req_vertex_b     (req_vertex_b),
      .req_vertex_c     (req_vertex_c),
      .req_query_vertex (req_query_vertex),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_word         (rsp_word),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .cnt_port         (cnt_port),
      .cnt_rdata        (cnt_rdata),
      .list_port        (list_port),
      .list_rdata       (list_rdata)
   );

   // list lengths
   mvat_count_mem u_count_mem (
      .clock      (clock),
      .port       (cnt_port),
      .rd_data_ff (cnt_rdata)
   );

   // list entries
   mvat_list_mem u_list_mem (
      .clock      (clock),
      .port       (list_port),
      .rd_data_ff (list_rdata)
   );

endmodule

>>> dv/mesh_vertex_adjacency_table_top_tb.sv
module mesh_vertex_adjacency_table_top_tb;

   // request code that the block ignores
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   typedef struct {
      logic [mvat_pkg::WORD_W-1:0] word;
      logic [1:0]                  status;
      logic                        last;
   } adj_word_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [1:0]                      req_type = mvat_pkg::REQ_ADD;
   logic [mvat_pkg::VIDX_W-1:0]     req_vertex_a = '0;
   logic [mvat_pkg::VIDX_W-1:0]     req_vertex_b = '0;
   logic [mvat_pkg::VIDX_W-1:0]     req_vertex_c = '0;
   logic [mvat_pkg::VIDX_W-1:0]     req_query_vertex = '0;
   logic                            csr_wr_en = 1'b0;
   logic [mvat_pkg::VCOUNT_W-1:0]   csr_wr_data = '0;
   logic                            rsp_valid;
   logic [mvat_pkg::WORD_W-1:0]     rsp_word;
   logic [1:0]                      rsp_status;
   logic                            rsp_last;

   // predicted state of the neighbour lists
   adj_word_type                    expected_words[$];
   logic [mvat_pkg::VCOUNT_W-1:0]   vertex_limit;
   int unsigned                     nbr_count [mvat_pkg::MAX_VERTICES];
   logic [mvat_pkg::VIDX_W-1:0]     nbr_list [mvat_pkg::MAX_VERTICES][mvat_pkg::LIST_SLOTS];
   int                              fail_count = 0;
   bit                              ignored_pending = 1'b0;
   int                              gap_odds = 0;

   mesh_vertex_adjacency_table_top DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_vertex_a     (req_vertex_a),
      .req_vertex_b     (req_vertex_b),
      .req_vertex_c     (req_vertex_c),
      .req_query_vertex (req_query_vertex),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_word         (rsp_word),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // empty every list
   function automatic void clear_lists();
      foreach (nbr_count[v]) nbr_count[v] = 0;
   endfunction

   // append n to the list of v unless present; report false when dropped as full
   function automatic bit link_neighbour(int unsigned v, logic [mvat_pkg::VIDX_W-1:0] n);
      for (int unsigned i = 0; i < nbr_count[v]; i++)
         if (nbr_list[v][i] == n) return 1'b1;
      if (nbr_count[v] >= mvat_pkg::LIST_SLOTS) return 1'b0;
      nbr_list[v][nbr_count[v]] = n;
      nbr_count[v]++;
      return 1'b1;
   endfunction

   function automatic void push_word(int unsigned w, logic [1:0] st, logic lst);
      adj_word_type item;
      item.word   = mvat_pkg::WORD_W'(w);
      item.status = st;
      item.last   = lst;
      expected_words.push_back(item);
   endfunction

   // work out the words an accepted request produces and update the lists
   function automatic void predict_words(logic [1:0] kind,
                                         logic [mvat_pkg::VIDX_W-1:0] a,
                                         logic [mvat_pkg::VIDX_W-1:0] b,
                                         logic [mvat_pkg::VIDX_W-1:0] c,
                                         logic [mvat_pkg::VIDX_W-1:0] q);
      int unsigned lim;
      bit ok;
      int unsigned cnt;
      lim = (vertex_limit > mvat_pkg::MAX_VERTICES) ? mvat_pkg::MAX_VERTICES : vertex_limit;
      case (kind)
         mvat_pkg::REQ_ADD: begin
            if (a >= lim || b >= lim || c >= lim) begin
               push_word(0, mvat_pkg::ST_REJECT, 1'b1);
            end else begin
               ok = 1'b1;
               ok = link_neighbour(a, b) && ok;
               ok = link_neighbour(a, c) && ok;
               ok = link_neighbour(b, a) && ok;
               ok = link_neighbour(b, c) && ok;
               ok = link_neighbour(c, a) && ok;
               ok = link_neighbour(c, b) && ok;
               push_word(0, ok ? mvat_pkg::ST_OK : mvat_pkg::ST_DROPPED, 1'b1);
            end
         end
         mvat_pkg::REQ_QUERY: begin
            if (q >= lim) begin
               for (int k = 0; k <= mvat_pkg::LIST_SLOTS; k++)
                  push_word(0, mvat_pkg::ST_BAD_QUERY, k == mvat_pkg::LIST_SLOTS);
            end else begin
               cnt = nbr_count[q];
               push_word(cnt, mvat_pkg::ST_OK, 1'b0);
               for (int k = 0; k < mvat_pkg::LIST_SLOTS; k++)
                  push_word((k < cnt) ? nbr_list[q][k] : 0, mvat_pkg::ST_OK,
                            k == mvat_pkg::LIST_SLOTS - 1);
            end
         end
         mvat_pkg::REQ_CLEAR: begin
            clear_lists();
            push_word(0, mvat_pkg::ST_OK, 1'b1);
         end
         default: ignored_pending = 1'b1;
      endcase
   endfunction

   // hand in one request and predict its words once it is taken
   task automatic send_req(input logic [1:0] kind, input int a, input int b,
                           input int c, input int q);
      start            <= 1'b1;
      req_type         <= kind;
      req_vertex_a     <= mvat_pkg::VIDX_W'(a);
      req_vertex_b     <= mvat_pkg::VIDX_W'(b);
      req_vertex_c     <= mvat_pkg::VIDX_W'(c);
      req_query_vertex <= mvat_pkg::VIDX_W'(q);
      do @(posedge clock); while (busy !== 1'b0);
      predict_words(kind, mvat_pkg::VIDX_W'(a), mvat_pkg::VIDX_W'(b),
                    mvat_pkg::VIDX_W'(c), mvat_pkg::VIDX_W'(q));
   endtask

   task automatic sender_gap(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // hold off until every expected word is in and the block is idle
   task automatic wait_for_drain();
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      if (ignored_pending) begin
         repeat (100) @(posedge clock);
         ignored_pending = 1'b0;
      end
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic write_vertex_count(input int unsigned value);
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mvat_pkg::VCOUNT_W'(value);
      @(posedge clock);
      vertex_limit = mvat_pkg::VCOUNT_W'(value);
      csr_wr_en   <= 1'b0;
   endtask

   // empty lists, the index extremes and a request type with no meaning
   task automatic test_basic_lists();
      send_req(mvat_pkg::REQ_QUERY, 0, 0, 0, 0);
      send_req(mvat_pkg::REQ_ADD, 0, 1, 2, 4095);
      send_req(mvat_pkg::REQ_ADD, 4095, 0, 4094, 0);
      send_req(mvat_pkg::REQ_QUERY, 4095, 4095, 4095, 0);
      send_req(mvat_pkg::REQ_QUERY, 0, 0, 0, 4095);
      send_req(REQ_UNKNOWN, 4095, 4095, 4095, 4095);
   endtask

   // repeated indices put a vertex in its own list
   task automatic test_degenerate_triangles();
      send_req(mvat_pkg::REQ_ADD, 5, 5, 5, 0);
      send_req(mvat_pkg::REQ_ADD, 5, 5, 6, 0);
      send_req(mvat_pkg::REQ_QUERY, 0, 0, 0, 5);
   endtask

   // fill one list, overflow it, then repeat a triangle already held
   task automatic test_full_list();
      for (int k = 0; k < 7; k++)
         send_req(mvat_pkg::REQ_ADD, 7, 100 + 2 * k, 101 + 2 * k, 0);
      send_req(mvat_pkg::REQ_ADD, 7, 100, 101, 0);
      send_req(mvat_pkg::REQ_QUERY, 0, 0, 0, 7);
   endtask

   task automatic test_clear();
      send_req(mvat_pkg::REQ_CLEAR, 0, 0, 0, 0);
      send_req(mvat_pkg::REQ_QUERY, 0, 0, 0, 7);
   endtask

   // vertex count at both ends and beyond the table size
   task automatic test_vertex_count_limits();
      write_vertex_count(16);
      send_req(mvat_pkg::REQ_ADD, 16, 0, 1, 0);
      send_req(mvat_pkg::REQ_QUERY, 0, 0, 0, 16);
      write_vertex_count(0);
      send_req(mvat_pkg::REQ_ADD, 0, 0, 0, 0);
      write_vertex_count(8191);
      send_req(mvat_pkg::REQ_QUERY, 0, 0, 0, 4095);
      write_vertex_count(1);
      send_req(mvat_pkg::REQ_ADD, 0, 0, 0, 0);
      send_req(mvat_pkg::REQ_QUERY, 0, 0, 0, 0);
   endtask

   // mostly a narrow window so lists fill; some anywhere, some at the limit
   function automatic int pick_vertex(int lim, int base);
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r < 7) v = base + $urandom_range(0, 23);
      else if (r < 9) v = $urandom_range(0, 4095);
      else v = lim - 1 + $urandom_range(0, 2);
      return (v > 4095) ? 4095 : v;
   endfunction

   task automatic test_random_traffic(input int n_items, input int unsigned vc,
                                      input bit idles);
      int lim;
      int base;
      int done;
      int r;
      logic [1:0] kind;
      write_vertex_count(vc);
      lim  = (vc > mvat_pkg::MAX_VERTICES) ? mvat_pkg::MAX_VERTICES : vc;
      base = (lim > 24) ? $urandom_range(0, lim - 24) : 0;
      done = 0;
      while (done < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 55) kind = mvat_pkg::REQ_ADD;
         else if (r < 93) kind = mvat_pkg::REQ_QUERY;
         else if (r < 95) kind = mvat_pkg::REQ_CLEAR;
         else kind = REQ_UNKNOWN;
         send_req(kind, pick_vertex(lim, base), pick_vertex(lim, base),
                  pick_vertex(lim, base), pick_vertex(lim, base));
         if (kind != REQ_UNKNOWN) done++;
         // change the gap rate now and then so quiet stretches appear
         if (done % 30 == 0) gap_odds = $urandom_range(0, 3);
         if (done == n_items / 2) wait_for_drain();
         else if (idles && gap_odds != 0 && $urandom_range(0, 3) < gap_odds)
            sender_gap($urandom_range(1, 12));
      end
   endtask

   // record a failed check; the block below compares each result word with the oldest expectation
   task automatic report_failure(input string what, input adj_word_type exp_w);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s: expected %0d/%0d/%0d, got %0d/%0d/%0d (word/status/last)",
                  $realtime, what, exp_w.word, exp_w.status, exp_w.last,
                  rsp_word, rsp_status, rsp_last);
   endtask

   always @(posedge clock) begin
      adj_word_type exp_w;
      if (rsp_valid === 1'b1) begin
         if (expected_words.size() == 0) begin
            exp_w = '{word: '0, status: '0, last: 1'b0};
            report_failure("unexpected word", exp_w);
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_word !== exp_w.word || rsp_status !== exp_w.status ||
                rsp_last !== exp_w.last)
               report_failure("word mismatch", exp_w);
         end
      end
   end

   initial begin
      #8000000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      vertex_limit = mvat_pkg::VCOUNT_W'(mvat_pkg::MAX_VERTICES);
      clear_lists();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_basic_lists();
      test_degenerate_triangles();
      test_full_list();
      test_clear();
      test_vertex_count_limits();
      test_random_traffic(120, mvat_pkg::MAX_VERTICES, 1'b1);
      test_random_traffic(100, $urandom_range(2, 40), 1'b1);
      test_random_traffic(75, $urandom_range(mvat_pkg::MAX_VERTICES + 1, 8191), 1'b1);
      test_random_traffic(60, mvat_pkg::MAX_VERTICES, 1'b0);

      // drain, then allow for the longest add before the verdict
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> files.f
rtl/mvat_pkg.sv
rtl/mvat_count_mem.sv
rtl/mvat_list_mem.sv
rtl/mvat_probe.sv
rtl/mvat_ctrl.sv
rtl/mesh_vertex_adjacency_table_top.sv
dv/mesh_vertex_adjacency_table_top_tb.sv
